>>> src/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg
// Shared constants, codes and types of the bounded circular list engine.
// ----------------------------------------------------------------------------
package bcle_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned IN_TDATA_W  = ((OP_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = STATUS_W + POS_W + COUNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Bit positions of the result fields inside the output word.
  localparam int unsigned OUT_POS_LSB   = STATUS_W;
  localparam int unsigned OUT_COUNT_LSB = STATUS_W + POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_ORD  = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_SEARCH   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

endpackage

>>> src/bounded_circular_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_circular_list_engine
// Ordered list of up to CAPACITY signed 32-bit values kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the slave stream carries an opcode and a value: insert at
//   head, insert at tail, ordered insert, remove first equal value, or
//   search for the first equal value. Every word gives exactly one result
//   word on the master stream with status, position and entry count.
//   One word is worked on at a time. The RAM does one read and one write
//   per cycle. A word goes from idle through a scan, a shift of entries
//   and a write of the new value, as its opcode needs, to the result. A
//   scan and the shift after it cover at most held_count + 1 entries.
//   The result sits in an output register, so the next word is taken while
//   an earlier result still waits. If the receiver stalls longer, the next
//   result holds in the sequencer and no further word is accepted.
//   Reset empties the list at once; the RAM contents need no clearing as
//   only entries below the count are read.
// ----------------------------------------------------------------------------
module bounded_circular_list_engine (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [2:0] opcode, [34:3] item_value, upper bits zero
  input  logic [bcle_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [1:0] status, [5:2] position, [10:6] entry_count, upper bits zero
  output logic [bcle_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  import bcle_pkg::*;

  res_t                   res;
  logic                   res_ready;
  mem_req_t               mem_req;
  logic [VALUE_W-1:0]     mem_rdata;
  logic                   out_valid_q;
  logic [OUT_FIELD_W-1:0] out_data_q;

  bcle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tdata[OP_W-1:0]),
    .in_value_i  (s_axis_tdata[OP_W+VALUE_W-1:OP_W]),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  bcle_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_data_q <= {res.entry_count, res.position, res.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

endmodule

>>> src/bcle_ram.sv
// ----------------------------------------------------------------------------
// bcle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bcle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/bcle_ctrl.sv
// ----------------------------------------------------------------------------
// bcle_ctrl
// Sequencer of the list: scans the entry RAM, shifts entries up or down one
// per cycle, writes the new value and holds the entry count.
// ----------------------------------------------------------------------------
module bcle_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bcle_pkg::OP_W-1:0]    in_opcode_i,
  input  logic [bcle_pkg::VALUE_W-1:0] in_value_i,
  output bcle_pkg::res_t            res_o,
  input  logic                      res_ready_i,
  output bcle_pkg::mem_req_t        mem_req_o,
  input  logic [bcle_pkg::VALUE_W-1:0] mem_rdata_i
);

  import bcle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic               ins_q, ins_d;
  logic               sv_q, sv_d;
  logic [CNT_W-1:0]   sidx_q, sidx_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   paddr_q, paddr_d;
  status_e            status_q, status_d;

  logic             lt, eq, hit, last;
  logic [CNT_W-1:0] k_end;
  logic [CNT_W-1:0] cnt_m1;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign lt     = $signed(val_q) < $signed(mem_rdata_i);
  assign eq     = (val_q == mem_rdata_i);
  // Ordered insert stops at the first entry not less than the value, except
  // that an equal head value lets the new value go behind the head.
  assign hit    = (op_q == OP_INS_ORD) ? ((sidx_q == '0) ? lt : (lt || eq)) : eq;
  assign last   = (sidx_q == cnt_m1);
  assign k_end  = hit ? sidx_q : cnt_q;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    k_d      = k_q;
    ins_d    = ins_q;
    sv_d     = 1'b0;
    sidx_d   = sidx_q;
    pend_d   = 1'b0;
    paddr_d  = paddr_q;
    status_d = status_q;

    in_ready_o      = 1'b0;
    mem_req_o.raddr = ptr_q[IDX_W-1:0];
    mem_req_o.we    = pend_q;
    mem_req_o.waddr = paddr_q;
    mem_req_o.wdata = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = op_e'(in_opcode_i);
          val_d    = in_value_i;
          ptr_d    = '0;
          k_d      = '0;
          ins_d    = 1'b1;
          status_d = STAT_ABSENT;
          state_d  = S_RESP;
          case (in_opcode_i)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_ORD: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else if (in_opcode_i == OP_INS_HEAD) begin
                ptr_d   = cnt_m1;
                rem_d   = cnt_q;
                state_d = S_SHIFT;
              end else if (in_opcode_i == OP_INS_TAIL || cnt_q == '0) begin
                k_d     = cnt_q;
                rem_d   = '0;
                state_d = S_SHIFT;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_REMOVE, OP_SEARCH: begin
              if (cnt_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Reads go out one per cycle; each compare looks at the entry
        // read in the cycle before.
        if (ptr_q < cnt_q) begin
          sv_d   = 1'b1;
          sidx_d = ptr_q;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        if (sv_q && (hit || last)) begin
          sv_d = 1'b0;
          case (op_q)
            OP_INS_ORD: begin
              k_d     = k_end;
              ins_d   = 1'b1;
              ptr_d   = cnt_m1;
              rem_d   = cnt_q - k_end;
              state_d = S_SHIFT;
            end
            OP_REMOVE: begin
              if (hit) begin
                k_d     = sidx_q;
                ins_d   = 1'b0;
                ptr_d   = sidx_q + CNT_W'(1);
                rem_d   = cnt_m1 - sidx_q;
                state_d = S_SHIFT;
              end else begin
                status_d = STAT_ABSENT;
                k_d      = '0;
                state_d  = S_RESP;
              end
            end
            OP_SEARCH: begin
              status_d = hit ? STAT_DONE : STAT_ABSENT;
              k_d      = hit ? sidx_q : '0;
              state_d  = S_RESP;
            end
            default: begin
              status_d = STAT_ABSENT;
              k_d      = '0;
              state_d  = S_RESP;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // The entry read now is written one place up (insert) or down
        // (remove) in the next cycle.
        if (rem_q != '0) begin
          pend_d = 1'b1;
          if (ins_q) begin
            paddr_d = ptr_q[IDX_W-1:0] + IDX_W'(1);
            ptr_d   = ptr_q - CNT_W'(1);
          end else begin
            paddr_d = ptr_q[IDX_W-1:0] - IDX_W'(1);
            ptr_d   = ptr_q + CNT_W'(1);
          end
          rem_d = rem_q - CNT_W'(1);
        end else if (ins_q) begin
          state_d = S_WRITE;
        end else begin
          cnt_d    = cnt_m1;
          status_d = STAT_DONE;
          state_d  = S_RESP;
        end
      end

      S_WRITE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = k_q[IDX_W-1:0];
        mem_req_o.wdata = val_q;
        cnt_d           = cnt_q + CNT_W'(1);
        status_d        = STAT_DONE;
        state_d         = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.valid       = (state_q == S_RESP);
  assign res_o.status      = status_q;
  assign res_o.position    = POS_W'(k_q);
  assign res_o.entry_count = COUNT_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      sv_q     <= 1'b0;
      pend_q   <= 1'b0;
      op_q     <= OP_INS_HEAD;
      val_q    <= '0;
      ptr_q    <= '0;
      rem_q    <= '0;
      k_q      <= '0;
      ins_q    <= 1'b0;
      sidx_q   <= '0;
      paddr_q  <= '0;
      status_q <= STAT_ABSENT;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sv_q     <= sv_d;
      pend_q   <= pend_d;
      op_q     <= op_d;
      val_q    <= val_d;
      ptr_q    <= ptr_d;
      rem_q    <= rem_d;
      k_q      <= k_d;
      ins_q    <= ins_d;
      sidx_q   <= sidx_d;
      paddr_q  <= paddr_d;
      status_q <= status_d;
    end
  end

endmodule

>>> src/bcle_checker.sv
// ----------------------------------------------------------------------------
// bcle_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module bcle_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bcle_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import bcle_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  entry_count;

  assign status      = m_axis_tdata[STATUS_W-1:0];
  assign position    = m_axis_tdata[OUT_POS_LSB +: POS_W];
  assign entry_count = m_axis_tdata[OUT_COUNT_LSB +: COUNT_W];

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // One word at a time: after an accepted word the input is closed.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in two cycles in a row");

  // A dropped insert only happens on a full list.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == STAT_FULL |->
      entry_count == COUNT_W'(CAPACITY) && position == '0)
    else $error("full status with list not full");

  // A missing value reports position zero.
  a_absent_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == STAT_ABSENT |-> position == '0)
    else $error("absent status with nonzero position");

endmodule

bind bounded_circular_list_engine bcle_checker u_bcle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
